### rtl/pstss_pkg.sv
package pstss_pkg;

  localparam int VOICES              = 16;
  localparam int TABLE_SIZE          = 2048;
  localparam int LEVEL_FULL          = 1024;
  localparam int PHASE_FRACTION_BITS = 16;

  localparam int NOTE_COUNT = 16;
  localparam int SINE_PEAK  = 7000;

  localparam int OP_W       = 3;
  localparam int VOICE_W    = 4;
  localparam int SAMPLE_W   = 16;
  localparam int IN_TDATA_W = 8;

  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int TABLE_W = $clog2(TABLE_SIZE);
  localparam int PHASE_W = TABLE_W + PHASE_FRACTION_BITS;
  localparam int STEP_W  = 22;
  localparam int SINE_W  = 14;
  localparam int LEVEL_W = $clog2(LEVEL_FULL + 1);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned PHASE_STEP_DIV = 64'd44100 << (30 - PHASE_FRACTION_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_KEY_ON  = 3'd1,
    OP_KEY_OFF = 3'd2,
    OP_FADE    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [TABLE_SIZE];
  typedef logic [STEP_W-1:0]        step_rom_t [VOICES];
  typedef longint unsigned          ratio_tab_t [NOTE_COUNT];

  // 2^(note/12 - 1) in Q30 for the default note set
  localparam ratio_tab_t PITCH_RATIO_Q30 = '{
    64'd536870912,  64'd602617224,  64'd676414964,  64'd716636690,
    64'd804397487,  64'd902905651,  64'd956595215,  64'd1073741824,
    64'd1205234447, 64'd1352829927, 64'd1433273380, 64'd1608794974,
    64'd1805811301, 64'd1913190429, 64'd2147483648, 64'd2410468894
  };

  // Quarter-wave symmetry plus Q30 Taylor series up to x^13.
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned a);
    longint unsigned u, q, r, x, x2, term, pos, neg, mag;
    logic signed [SINE_W-1:0] val;
    u = 64'(a) * 4;
    q = u / TABLE_SIZE;
    r = u % TABLE_SIZE;
    if (q[0]) r = TABLE_SIZE - r;
    if (r == TABLE_SIZE) begin
      mag = SINE_PEAK;
    end else begin
      x    = (HALF_PI_Q30 * r) / TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 0;
      term = ((term * x2) >> 30) / 6;   neg = neg + term;
      term = ((term * x2) >> 30) / 20;  pos = pos + term;
      term = ((term * x2) >> 30) / 42;  neg = neg + term;
      term = ((term * x2) >> 30) / 72;  pos = pos + term;
      term = ((term * x2) >> 30) / 110; neg = neg + term;
      term = ((term * x2) >> 30) / 156; pos = pos + term;
      pos  = (pos > neg) ? pos - neg : 0;
      mag  = (pos * SINE_PEAK) >> 30;
    end
    val = SINE_W'(mag);
    if (q >= 2) val = -val;
    return val;
  endfunction

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t t;
    for (int i = 0; i < TABLE_SIZE; i++) t[i] = sine_entry(i);
    return t;
  endfunction

  function automatic step_rom_t step_rom_init();
    step_rom_t t;
    longint unsigned num;
    for (int i = 0; i < VOICES; i++) begin
      num  = PITCH_RATIO_Q30[i % NOTE_COUNT] * TABLE_SIZE * 440;
      t[i] = STEP_W'((num + PHASE_STEP_DIV / 2) / PHASE_STEP_DIV);
    end
    return t;
  endfunction

endpackage

### rtl/polyphonic_sine_table_synth_top.sv
// Sample tick: voices issued one per cycle, then the 2-stage multiply pipe drains;
//   the result beat is registered once the pipe is empty (sooner when the
//   last voices are silent), later while an earlier result beat is still stalled.
// Input taken again the cycle after the result is registered, so a new tick waits for
//   the previous sample. Key on / key off / fade / clear: taken while idle, no result.
// Reset (rst_n low, synchronous): all levels and phases zero, sequencer idle,
//   no result pending.
module polyphonic_sine_table_synth_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pstss_pkg::IN_TDATA_W-1:0]    in_tdata,   // [3:0] voice, rest zero
  input  logic [pstss_pkg::OP_W-1:0]          in_tuser,   // [2:0] operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pstss_pkg::SAMPLE_W-1:0]      out_tdata   // [15:0] sample (signed)
);
  import pstss_pkg::*;

  localparam int PROD_W = SINE_W + LEVEL_W + 1;
  localparam int SUM_W  = SAMPLE_W + 1;

  // Sine table is a ROM with registered read; steps are a small constant table.
  localparam sine_rom_t SineRom = sine_rom_init();
  localparam step_rom_t StepRom = step_rom_init();
  localparam logic signed [PROD_W-1:0] VolDiv = PROD_W'(LEVEL_FULL);
  localparam logic signed [SAMPLE_W-1:0] SatMax = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SatMin = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,    // issue one voice per cycle
    ST_DRAIN   // wait for the MAC pipe to empty and the output to be free, then post the sample
  } state_t;

  state_t state_r;

  logic [LEVEL_W-1:0] level_r [VOICES];
  logic [PHASE_W-1:0] phase_r [VOICES];

  logic [VIDX_W-1:0] cnt_r;   // voice counter of the serial sum

  // MAC pipe: stage 1 holds ROM data and level, stage 2 the product
  logic                       s1_vld_r;
  logic signed [SINE_W-1:0]   s1_sine_r;
  logic [LEVEL_W-1:0]         s1_lvl_r;
  logic                       s2_vld_r;
  logic signed [PROD_W-1:0]   s2_prod_r;

  logic signed [SAMPLE_W-1:0] mix_r;
  logic signed [SAMPLE_W-1:0] mix_nxt;

  logic                       out_vld_r;
  logic [SAMPLE_W-1:0]        out_data_r;

  logic [VOICE_W-1:0]         in_voice;
  logic                       in_beat;
  logic                       voice_ok;
  logic [VIDX_W-1:0]          in_idx;
  logic [LEVEL_W-1:0]         cur_lvl;
  logic [PHASE_W-1:0]         cur_phase;
  logic signed [PROD_W-1:0]   scaled;
  logic signed [SUM_W-1:0]    sum;
  logic                       post_smp;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign in_voice = in_tdata[VOICE_W-1:0];
  assign in_beat  = in_tvalid && in_tready;
  assign voice_ok = (32'(in_voice) < VOICES);
  assign in_idx   = VIDX_W'(in_voice);

  assign cur_lvl   = level_r[cnt_r];
  assign cur_phase = phase_r[cnt_r];

  // pipe empty and output register free: post the finished mix
  assign post_smp = (state_r == ST_DRAIN) && !s1_vld_r && !s2_vld_r &&
                    (!out_vld_r || out_tready);

  // level/LEVEL_FULL scaling truncates toward zero, then saturating add
  always_comb begin
    scaled = s2_prod_r / VolDiv;
    sum    = SUM_W'(mix_r) + SUM_W'(scaled);
    if (sum > SUM_W'(SatMax)) begin
      mix_nxt = SatMax;
    end else if (sum < SUM_W'(SatMin)) begin
      mix_nxt = SatMin;
    end else begin
      mix_nxt = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      mix_r     <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        level_r[i] <= '0;
        phase_r[i] <= '0;
      end
    end else begin
      if (post_smp) begin
        out_vld_r  <= 1'b1;
        out_data_r <= mix_r;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end

      // stage 1 -> stage 2: one multiply
      s2_vld_r  <= s1_vld_r;
      s2_prod_r <= s1_sine_r * $signed({1'b0, s1_lvl_r});

      // stage 2: accumulate; cleared once the sample is posted
      if (s2_vld_r) begin
        mix_r <= mix_nxt;
      end else if (post_smp) begin
        mix_r <= '0;
      end

      s1_vld_r <= (state_r == ST_RUN) && (cur_lvl != '0);

      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            unique case (in_tuser)
              OP_TICK: begin
                state_r <= ST_RUN;
                cnt_r   <= '0;
              end
              OP_KEY_ON: begin
                if (voice_ok) begin
                  phase_r[in_idx] <= '0;
                  level_r[in_idx] <= LEVEL_W'(LEVEL_FULL);
                end
              end
              OP_KEY_OFF: begin
                if (voice_ok) level_r[in_idx] <= '0;
              end
              OP_FADE: begin
                for (int i = 0; i < VOICES; i++) begin
                  if (level_r[i] == LEVEL_W'(LEVEL_FULL)) begin
                    level_r[i] <= LEVEL_W'(LEVEL_FULL - 1);
                  end
                end
              end
              OP_CLEAR: begin
                for (int i = 0; i < VOICES; i++) level_r[i] <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_RUN: begin
          // ROM reads the old phase; for a sounding voice the phase advances and a level below full decays right away
          s1_sine_r <= SineRom[cur_phase[PHASE_W-1 -: TABLE_W]];
          s1_lvl_r  <= cur_lvl;
          if (cur_lvl != '0) begin
            phase_r[cnt_r] <= cur_phase + PHASE_W'(StepRom[cnt_r]);
            if (cur_lvl < LEVEL_W'(LEVEL_FULL)) level_r[cnt_r] <= cur_lvl - 1'b1;
          end
          if (cnt_r == VIDX_W'(VOICES - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_DRAIN: begin
          if (post_smp) state_r <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/pstss_chk.sv
module pstss_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [pstss_pkg::OP_W-1:0]        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pstss_pkg::SAMPLE_W-1:0]    out_tdata
);
  import pstss_pkg::*;

  logic in_beat;
  logic tick_beat;
  logic other_beat;

  assign in_beat    = in_tvalid && in_tready;
  assign tick_beat  = in_beat && (in_tuser == OP_TICK);
  assign other_beat = in_beat && (in_tuser != OP_TICK);

  // a held result beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // a tick occupies the sequencer
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_beat |=> !in_tready)
    else $error("input taken right after a tick");

  // control ops finish in the accept cycle
  a_ctrl_fast: assert property (@(posedge clk) disable iff (!rst_n)
    other_beat |=> in_tready)
    else $error("control op stalled the input");

  // a new sample is posted only when the sequencer goes idle
  a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("sample posted while sequencer busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat pending after reset");

endmodule

bind polyphonic_sine_table_synth_top pstss_chk u_pstss_chk (.*);
